@@ rtl/rcrf_pkg.sv @@
// ----------------------------------------------------------------------------
// RTC CMOS register file package
// Shared types, index codes and BCD conversion helpers.
// ----------------------------------------------------------------------------
package rcrf_pkg;

  typedef enum logic [1:0] {
    KIND_WR_INDEX  = 2'd0,
    KIND_WR_DATA   = 2'd1,
    KIND_RD_INDEX  = 2'd2,
    KIND_RD_DATA   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_BYTE   = 2'd1,
    ST_INDEX_READ = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_FLOPPY    = 2'd0,
    CFG_DISK      = 2'd1,
    CFG_EQUIPMENT = 2'd2,
    CFG_BOOT      = 2'd3
  } cfg_idx_t;

  localparam logic [7:0] IDX_SEC       = 8'h00;
  localparam logic [7:0] IDX_ALARM_SEC = 8'h01;
  localparam logic [7:0] IDX_MIN       = 8'h02;
  localparam logic [7:0] IDX_ALARM_MIN = 8'h03;
  localparam logic [7:0] IDX_HOUR      = 8'h04;
  localparam logic [7:0] IDX_ALARM_HR  = 8'h05;
  localparam logic [7:0] IDX_WEEKDAY   = 8'h06;
  localparam logic [7:0] IDX_DAY       = 8'h07;
  localparam logic [7:0] IDX_MONTH     = 8'h08;
  localparam logic [7:0] IDX_YEAR      = 8'h09;
  localparam logic [7:0] IDX_REG_A     = 8'h0a;
  localparam logic [7:0] IDX_REG_B     = 8'h0b;
  localparam logic [7:0] IDX_REG_D     = 8'h0d;
  localparam logic [7:0] IDX_FLOPPY    = 8'h10;
  localparam logic [7:0] IDX_DISK      = 8'h12;
  localparam logic [7:0] IDX_EQUIPMENT = 8'h14;
  localparam logic [7:0] IDX_CENTURY   = 8'h32;
  localparam logic [7:0] IDX_BOOT_HI   = 8'h38;
  localparam logic [7:0] IDX_BOOT_LO   = 8'h3d;

  localparam logic [7:0] REG_A_FIXED   = 8'h20;
  localparam logic [7:0] REG_D_VALUE   = 8'h80;
  localparam logic [7:0] PM_FLAG       = 8'h80;
  localparam logic [7:0] HOURS_HALF    = 8'd12;
  localparam logic [3:0] RATE_RESET    = 4'd6;

  typedef struct packed {
    logic [1:0] kind;
    logic       byte_access;
    logic [7:0] data;
    logic [5:0] now_second;
    logic [5:0] now_minute;
    logic [4:0] now_hour;
    logic [2:0] now_weekday;
    logic [4:0] now_day;
    logic [3:0] now_month;
    logic [6:0] now_year;
    logic [6:0] now_century;
  } item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    status_t    status;
  } result_t;

  // Division by ten through a reciprocal multiply, exact for all byte values.
  function automatic logic [7:0] enc(input logic [7:0] v, input logic bin);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  r;
    prod = {8'd0, v} * 16'd205;
    q    = prod[15:11];
    r    = v - 8'({3'd0, q} * 8'd10);
    if (bin) begin
      return v;
    end
    return {q[3:0], r[3:0]};
  endfunction

  function automatic logic [7:0] dec(input logic [7:0] b, input logic bin);
    logic [7:0] tens;
    tens = 8'({4'd0, b[7:4]} * 8'd10);
    if (bin) begin
      return b;
    end
    return tens + {4'd0, b[3:0]};
  endfunction

  function automatic logic [7:0] mod12(input logic [7:0] h);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  r;
    prod = {8'd0, h} * 16'd171;
    q    = prod[15:11];
    r    = h - 8'({3'd0, q} * HOURS_HALF);
    if (r >= HOURS_HALF) begin
      r = r - HOURS_HALF;
    end
    return r;
  endfunction

  function automatic logic [7:0] enc_hour(input logic [7:0] h, input logic bin,
                                          input logic h24);
    if (h24 || h <= HOURS_HALF) begin
      return enc(h, bin);
    end
    return enc(mod12(h), bin) | PM_FLAG;
  endfunction

  function automatic logic [7:0] dec_hour(input logic [7:0] b, input logic bin,
                                          input logic h24);
    if (h24 || !b[7]) begin
      return dec(b, bin);
    end
    return dec({1'b0, b[6:0]}, bin) + HOURS_HALF;
  endfunction

endpackage

@@ rtl/rtc_cmos_register_file_top.sv @@
// ----------------------------------------------------------------------------
// RTC CMOS register file top level
// Index/data port register file with an input register and a result register.
//
//   Channel   Direction  Handshake            Payload
//   in        input      in_valid / in_stall  kind, byte_access, data, now_*
//   out       output     out_valid/out_stall  read_byte, status
//   cfg       input      cfg_we               cfg_index, cfg_data
//
// One transaction is taken per cycle while in_stall is low. The path is an
// input register, the register file core, then a result register. Reset is
// synchronous; it clears the valid flags and returns the register file state
// to its reset values. A stall on the output holds both stages and raises
// in_stall only while both stages are full.
// ----------------------------------------------------------------------------
module rtc_cmos_register_file_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic        byte_access,
  input  logic [7:0]  data,
  input  logic [5:0]  now_second,
  input  logic [5:0]  now_minute,
  input  logic [4:0]  now_hour,
  input  logic [2:0]  now_weekday,
  input  logic [4:0]  now_day,
  input  logic [3:0]  now_month,
  input  logic [6:0]  now_year,
  input  logic [6:0]  now_century,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_byte,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  logic              s1_valid;
  rcrf_pkg::item_t   s1_item;
  rcrf_pkg::result_t core_result;
  logic              advance;
  logic              accept;
  logic              fire;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;
  assign fire     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.kind        <= kind;
      s1_item.byte_access <= byte_access;
      s1_item.data        <= data;
      s1_item.now_second  <= now_second;
      s1_item.now_minute  <= now_minute;
      s1_item.now_hour    <= now_hour;
      s1_item.now_weekday <= now_weekday;
      s1_item.now_day     <= now_day;
      s1_item.now_month   <= now_month;
      s1_item.now_year    <= now_year;
      s1_item.now_century <= now_century;
    end
    if (fire) begin
      read_byte <= core_result.read_byte;
      status    <= core_result.status;
    end
  end

  rcrf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (s1_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (core_result)
  );

`ifndef SYNTH
  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != rcrf_pkg::ST_OK) |-> read_byte == 8'd0)
    else $error("error transaction carries read data");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled while a stage is empty");

  a_moves_on: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_valid |=> out_valid)
    else $error("staged transaction did not reach the output");
`endif

endmodule

@@ rtl/rcrf_core.sv @@
// ----------------------------------------------------------------------------
// RTC CMOS register file core
// Holds the index, alarm, mode and CMOS bytes and resolves one access.
// ----------------------------------------------------------------------------
module rcrf_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  rcrf_pkg::item_t       item,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [11:0]           cfg_data,
  output rcrf_pkg::result_t     result
);

  logic [7:0]  index_reg;
  logic [7:0]  alarm_sec;
  logic [7:0]  alarm_min;
  logic [7:0]  alarm_hr;
  logic [3:0]  rate_divider;
  logic [2:0]  irq_enables;
  logic        binary_mode;
  logic        hour24_mode;
  logic [7:0]  floppy_type;
  logic [7:0]  disk_type;
  logic [7:0]  equipment_byte;
  logic [11:0] boot_order;

  logic        wr_index;
  logic        wr_data;
  logic [7:0]  rd_value;

  assign wr_index = fire && item.byte_access && (item.kind == rcrf_pkg::KIND_WR_INDEX);
  assign wr_data  = fire && item.byte_access && (item.kind == rcrf_pkg::KIND_WR_DATA);

  always_ff @(posedge clk) begin
    if (rst) begin
      index_reg      <= '0;
      alarm_sec      <= '0;
      alarm_min      <= '0;
      alarm_hr       <= '0;
      rate_divider   <= rcrf_pkg::RATE_RESET;
      irq_enables    <= '0;
      binary_mode    <= 1'b1;
      hour24_mode    <= 1'b1;
      floppy_type    <= '0;
      disk_type      <= '0;
      equipment_byte <= '0;
      boot_order     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (rcrf_pkg::cfg_idx_t'(cfg_index))
          rcrf_pkg::CFG_FLOPPY:    floppy_type    <= cfg_data[7:0];
          rcrf_pkg::CFG_DISK:      disk_type      <= cfg_data[7:0];
          rcrf_pkg::CFG_EQUIPMENT: equipment_byte <= cfg_data[7:0];
          rcrf_pkg::CFG_BOOT:      boot_order     <= cfg_data;
          default: ;
        endcase
      end
      if (wr_index) begin
        index_reg <= item.data;
      end
      if (wr_data) begin
        unique case (index_reg)
          rcrf_pkg::IDX_ALARM_SEC: alarm_sec <= rcrf_pkg::dec(item.data, binary_mode);
          rcrf_pkg::IDX_ALARM_MIN: alarm_min <= rcrf_pkg::dec(item.data, binary_mode);
          rcrf_pkg::IDX_ALARM_HR:
            alarm_hr <= rcrf_pkg::dec_hour(item.data, binary_mode, hour24_mode);
          rcrf_pkg::IDX_REG_A: rate_divider <= item.data[3:0];
          rcrf_pkg::IDX_REG_B: begin
            irq_enables <= item.data[6:4];
            binary_mode <= item.data[2];
            hour24_mode <= item.data[1];
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (index_reg)
      rcrf_pkg::IDX_SEC:       rd_value = rcrf_pkg::enc({2'd0, item.now_second}, binary_mode);
      rcrf_pkg::IDX_ALARM_SEC: rd_value = rcrf_pkg::enc(alarm_sec, binary_mode);
      rcrf_pkg::IDX_MIN:       rd_value = rcrf_pkg::enc({2'd0, item.now_minute}, binary_mode);
      rcrf_pkg::IDX_ALARM_MIN: rd_value = rcrf_pkg::enc(alarm_min, binary_mode);
      rcrf_pkg::IDX_HOUR:
        rd_value = rcrf_pkg::enc_hour({3'd0, item.now_hour}, binary_mode, hour24_mode);
      rcrf_pkg::IDX_ALARM_HR:
        rd_value = rcrf_pkg::enc_hour(alarm_hr, binary_mode, hour24_mode);
      rcrf_pkg::IDX_WEEKDAY:   rd_value = rcrf_pkg::enc({5'd0, item.now_weekday}, binary_mode);
      rcrf_pkg::IDX_DAY:       rd_value = rcrf_pkg::enc({3'd0, item.now_day}, binary_mode);
      rcrf_pkg::IDX_MONTH:     rd_value = rcrf_pkg::enc({4'd0, item.now_month}, binary_mode);
      rcrf_pkg::IDX_YEAR:      rd_value = rcrf_pkg::enc({1'b0, item.now_year}, binary_mode);
      rcrf_pkg::IDX_REG_A:     rd_value = rcrf_pkg::REG_A_FIXED | {4'd0, rate_divider};
      rcrf_pkg::IDX_REG_B:
        rd_value = {1'b0, irq_enables, 1'b0, binary_mode, hour24_mode, 1'b0};
      rcrf_pkg::IDX_REG_D:     rd_value = rcrf_pkg::REG_D_VALUE;
      rcrf_pkg::IDX_FLOPPY:    rd_value = floppy_type;
      rcrf_pkg::IDX_DISK:      rd_value = disk_type;
      rcrf_pkg::IDX_EQUIPMENT: rd_value = equipment_byte;
      rcrf_pkg::IDX_CENTURY:   rd_value = rcrf_pkg::enc({1'b0, item.now_century}, binary_mode);
      rcrf_pkg::IDX_BOOT_HI:   rd_value = {boot_order[11:8], 4'h1};
      rcrf_pkg::IDX_BOOT_LO:   rd_value = boot_order[7:0];
      default:                 rd_value = '0;
    endcase
  end

  always_comb begin
    result.read_byte = '0;
    result.status    = rcrf_pkg::ST_OK;
    if (!item.byte_access) begin
      result.status = rcrf_pkg::ST_NOT_BYTE;
    end else if (item.kind == rcrf_pkg::KIND_RD_INDEX) begin
      result.status = rcrf_pkg::ST_INDEX_READ;
    end else if (item.kind == rcrf_pkg::KIND_RD_DATA) begin
      result.read_byte = rd_value;
    end
  end

endmodule
